// ----- rtl/length_prefixed_command_parser_macros.svh -----
// Assertion macros shared by the parser RTL.
`ifndef LENGTH_PREFIXED_COMMAND_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lpcp_pkg.sv -----
`default_nettype none

package lpcp_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int DIGIT_LIMIT  = 15;
   localparam int DIGIT_WIDTH  = 4;
   localparam int LEN_WIDTH    = 17;
   localparam int ACC_WIDTH    = LEN_WIDTH + 4;
   localparam int CFG_WIDTH    = 16;
   localparam int CFG_IDX_WIDTH = 2;
   localparam int CMP_WIDTH    = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int LEN_CNT_WIDTH = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;

   localparam logic [LEN_WIDTH-1:0] LEN_SAT = {LEN_WIDTH{1'b1}};
   localparam logic [7:0] PIPE_CHAR  = 8'h7C;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   localparam logic [CFG_WIDTH-1:0] COMMAND_LIMIT_RESET  = 16'd64;
   localparam logic [CFG_WIDTH-1:0] FILENAME_LIMIT_RESET = 16'd256;
   localparam logic [CFG_WIDTH-1:0] CONTENT_LIMIT_RESET  = 16'd4096;

   // register indexes on the csr port
   localparam logic [CFG_IDX_WIDTH-1:0] REG_COMMAND_LIMIT  = 2'd0;
   localparam logic [CFG_IDX_WIDTH-1:0] REG_FILENAME_LIMIT = 2'd1;
   localparam logic [CFG_IDX_WIDTH-1:0] REG_CONTENT_LIMIT  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_COMMAND  = 2'd0;
   localparam logic [1:0] KIND_FILENAME = 2'd1;
   localparam logic [1:0] KIND_CONTENT  = 2'd2;
   localparam logic [1:0] KIND_VERDICT  = 2'd3;

   // result queue
   localparam int FIFO_DEPTH     = 2;
   localparam int FIFO_PTR_WIDTH = 1;
   localparam int FIFO_CNT_WIDTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       accepted;
      logic       with_arguments;
      logic       last_of_message;
   } rsp_type;

   // everything one byte produces: an optional payload and an optional verdict
   typedef struct packed {
      logic       has_payload;
      logic [1:0] payload_kind;
      logic [7:0] payload_byte;
      logic       has_verdict;
      logic       accepted;
      logic       with_arguments;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/length_prefixed_command_parser.sv -----
`default_nettype none

// Length-prefixed command parser. Takes one message byte per clock on req_
// while req_stall is low (command|digits|filename|digits|content, or a bare
// command) and returns the command, filename and content bytes on rsp_ tagged
// by kind, then a verdict on the end-of-message byte. Each byte goes into an
// input register and is fully parsed there once the result queue has room; its
// result then goes through the result queue to rsp_. The output delivers one
// result per clock while rsp_stall is low; an end-of-message byte with a
// payload byte leaves in two transactions; a two-entry result queue between
// the parser and rsp_ absorbs this and lets req_ keep moving while a result
// waits. The csr_ port is always ready and must only be written while no
// message is in flight.
module length_prefixed_command_parser (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire lpcp_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output lpcp_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lpcp_pkg::CFG_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [lpcp_pkg::CFG_WIDTH-1:0]       csr_data
);

`include "length_prefixed_command_parser_macros.svh"

   localparam int CountWidth  = lpcp_pkg::COUNT_WIDTH;
   localparam int CmpWidth    = lpcp_pkg::CMP_WIDTH;
   localparam int LenWidth    = lpcp_pkg::LEN_WIDTH;
   localparam int LenCntWidth = lpcp_pkg::LEN_CNT_WIDTH;
   localparam int AccWidth    = lpcp_pkg::ACC_WIDTH;
   localparam int DigitWidth  = lpcp_pkg::DIGIT_WIDTH;
   localparam int PtrWidth    = lpcp_pkg::FIFO_PTR_WIDTH;
   localparam int FcntWidth   = lpcp_pkg::FIFO_CNT_WIDTH;

   localparam logic [2:0] PH_CMD   = 3'd0;
   localparam logic [2:0] PH_FDIG  = 3'd1;
   localparam logic [2:0] PH_FNAME = 3'd2;
   localparam logic [2:0] PH_FPIPE = 3'd3;
   localparam logic [2:0] PH_CDIG  = 3'd4;
   localparam logic [2:0] PH_CONT  = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   // configuration
   logic [lpcp_pkg::CFG_WIDTH-1:0] command_limit_ff;
   logic [lpcp_pkg::CFG_WIDTH-1:0] filename_limit_ff;
   logic [lpcp_pkg::CFG_WIDTH-1:0] content_limit_ff;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   lpcp_pkg::req_type s1_item_ff;
   logic              req_accept;
   logic              s1_go;
   logic              room;

   // parser state
   logic [2:0]            phase_ff, phase_in;
   logic [CountWidth-1:0] field_count_ff, field_count_in;
   logic [DigitWidth-1:0] digit_count_ff, digit_count_in;
   logic [LenWidth-1:0]   length_value_ff, length_value_in;
   logic                  failed_ff, failed_in;
   logic                  saw_pipe_ff, saw_pipe_in;

   // datapath helpers
   logic                           is_pipe;
   logic                           is_digit;
   logic [CountWidth-1:0]          count_inc;
   logic [CountWidth-1:0]          count_dec;
   logic                           command_too_long;
   logic [lpcp_pkg::CFG_WIDTH-1:0] digit_limit;
   logic                           length_too_big;
   logic [LenCntWidth-1:0]         length_wide;
   logic [CountWidth-1:0]          length_count;
   logic [AccWidth-1:0]            acc_sum;
   logic [LenWidth-1:0]            acc_next;

   // result queue
   lpcp_pkg::entry_type fifo_mem_ff [lpcp_pkg::FIFO_DEPTH];
   lpcp_pkg::entry_type entry_in;
   lpcp_pkg::entry_type head;
   logic [PtrWidth-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FcntWidth-1:0] fifo_count_ff, fifo_count_in;
   logic                 half_ff, half_in;
   logic                 push, pop, rsp_take, show_payload;

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_limit_ff  <= lpcp_pkg::COMMAND_LIMIT_RESET;
         filename_limit_ff <= lpcp_pkg::FILENAME_LIMIT_RESET;
         content_limit_ff  <= lpcp_pkg::CONTENT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lpcp_pkg::REG_COMMAND_LIMIT:  command_limit_ff  <= csr_data;
            lpcp_pkg::REG_FILENAME_LIMIT: filename_limit_ff <= csr_data;
            lpcp_pkg::REG_CONTENT_LIMIT:  content_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   assign room        = fifo_count_ff != FcntWidth'(lpcp_pkg::FIFO_DEPTH);
   assign req_stall   = s1_valid_ff && !room;
   assign req_accept  = req_valid && !req_stall;
   assign s1_go       = s1_valid_ff && room;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_data;
      end
   end

   // ---------------- parser datapath ----------------
   assign is_pipe  = s1_item_ff.data_byte == lpcp_pkg::PIPE_CHAR;
   assign is_digit = (s1_item_ff.data_byte >= lpcp_pkg::DIGIT_ZERO) &&
                     (s1_item_ff.data_byte <= lpcp_pkg::DIGIT_NINE);

   assign count_inc = field_count_ff + CountWidth'(1);
   assign count_dec = field_count_ff - CountWidth'(1);
   assign command_too_long = CmpWidth'(count_inc) >= CmpWidth'(command_limit_ff);

   assign digit_limit    = (phase_ff == PH_FDIG) ? filename_limit_ff : content_limit_ff;
   assign length_too_big = length_value_ff >= LenWidth'(digit_limit);
   assign length_wide    = LenCntWidth'(length_value_ff);
   assign length_count   = length_wide[CountWidth-1:0];

   // times ten plus digit; the sum cannot wrap, so one compare saturates
   assign acc_sum  = (AccWidth'(length_value_ff) << 3) + (AccWidth'(length_value_ff) << 1)
                     + AccWidth'(s1_item_ff.data_byte[3:0]);
   assign acc_next = (acc_sum > AccWidth'(lpcp_pkg::LEN_SAT)) ? lpcp_pkg::LEN_SAT
                                                                : acc_sum[LenWidth-1:0];

   always_comb begin
      logic ok;
      phase_in        = phase_ff;
      field_count_in  = field_count_ff;
      digit_count_in  = digit_count_ff;
      length_value_in = length_value_ff;
      failed_in       = failed_ff;
      saw_pipe_in     = saw_pipe_ff;
      entry_in        = '0;
      ok              = 1'b0;
      if (s1_go) begin
         if (!failed_ff) begin
            unique case (phase_ff) inside
               PH_CMD: begin
                  if (is_pipe) begin
                     if (field_count_ff == '0) begin
                        failed_in = 1'b1;
                     end else begin
                        saw_pipe_in = 1'b1;
                        phase_in    = PH_FDIG;
                     end
                  end else begin
                     field_count_in = count_inc;
                     if (command_too_long) begin
                        failed_in = 1'b1;
                     end else begin
                        entry_in.has_payload  = 1'b1;
                        entry_in.payload_kind = lpcp_pkg::KIND_COMMAND;
                        entry_in.payload_byte = s1_item_ff.data_byte;
                     end
                  end
               end
               PH_FDIG, PH_CDIG: begin
                  if (is_pipe) begin
                     if (digit_count_ff == '0 || length_too_big) begin
                        failed_in = 1'b1;
                     end else begin
                        field_count_in  = length_count;
                        digit_count_in  = '0;
                        length_value_in = '0;
                        if (length_count == '0) begin
                           phase_in = (phase_ff == PH_FDIG) ? PH_FPIPE : PH_DONE;
                        end else begin
                           phase_in = (phase_ff == PH_FDIG) ? PH_FNAME : PH_CONT;
                        end
                     end
                  end else if (!is_digit ||
                               digit_count_ff >= DigitWidth'(lpcp_pkg::DIGIT_LIMIT)) begin
                     failed_in = 1'b1;
                  end else begin
                     digit_count_in  = digit_count_ff + DigitWidth'(1);
                     length_value_in = acc_next;
                  end
               end
               PH_FNAME, PH_CONT: begin
                  entry_in.has_payload  = 1'b1;
                  entry_in.payload_kind = (phase_ff == PH_FNAME) ? lpcp_pkg::KIND_FILENAME
                                                                 : lpcp_pkg::KIND_CONTENT;
                  entry_in.payload_byte = s1_item_ff.data_byte;
                  field_count_in        = count_dec;
                  if (count_dec == '0) begin
                     phase_in = (phase_ff == PH_FNAME) ? PH_FPIPE : PH_DONE;
                  end
               end
               PH_FPIPE: begin
                  if (is_pipe) begin
                     phase_in = PH_CDIG;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (s1_item_ff.end_of_message) begin
            ok = !failed_in && (phase_in == PH_CMD || phase_in == PH_DONE);
            entry_in.has_verdict    = 1'b1;
            entry_in.accepted       = ok;
            entry_in.with_arguments = ok && saw_pipe_in;
            // start the next message from scratch
            phase_in        = PH_CMD;
            field_count_in  = '0;
            digit_count_in  = '0;
            length_value_in = '0;
            failed_in       = 1'b0;
            saw_pipe_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_CMD;
         field_count_ff  <= '0;
         digit_count_ff  <= '0;
         length_value_ff <= '0;
         failed_ff       <= 1'b0;
         saw_pipe_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         field_count_ff  <= field_count_in;
         digit_count_ff  <= digit_count_in;
         length_value_ff <= length_value_in;
         failed_ff       <= failed_in;
         saw_pipe_ff     <= saw_pipe_in;
      end
   end

   // ---------------- result queue ----------------
   assign push = s1_go && (entry_in.has_payload || entry_in.has_verdict);
   assign head = fifo_mem_ff[rd_ptr_ff];

   assign rsp_valid    = fifo_count_ff != '0;
   assign show_payload = head.has_payload && !half_ff;
   assign rsp_take     = rsp_valid && !rsp_stall;
   // an entry with payload and verdict leaves over two transactions
   assign pop          = rsp_take && !(show_payload && head.has_verdict);
   assign half_in      = rsp_take ? (show_payload && head.has_verdict) : half_ff;

   assign fifo_count_in = fifo_count_ff + FcntWidth'(push) - FcntWidth'(pop);

   always_comb begin
      if (show_payload) begin
         rsp_data.out_kind        = head.payload_kind;
         rsp_data.out_byte        = head.payload_byte;
         rsp_data.accepted        = 1'b0;
         rsp_data.with_arguments  = 1'b0;
         rsp_data.last_of_message = 1'b0;
      end else begin
         rsp_data.out_kind        = lpcp_pkg::KIND_VERDICT;
         rsp_data.out_byte        = '0;
         rsp_data.accepted        = head.accepted;
         rsp_data.with_arguments  = head.with_arguments;
         rsp_data.last_of_message = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
         half_ff       <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrWidth'(1);
         end
         fifo_count_ff <= fifo_count_in;
         half_ff       <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   // ---------------- assertions ----------------
   `LPCP_ASSERT_SAME(a_queue_bound, clock, reset,
      1'b1, fifo_count_ff <= FcntWidth'(lpcp_pkg::FIFO_DEPTH),
      "result queue over its depth")
   `LPCP_ASSERT_SAME(a_last_is_verdict, clock, reset,
      rsp_valid, rsp_data.last_of_message == (rsp_data.out_kind == lpcp_pkg::KIND_VERDICT),
      "last_of_message does not match verdict kind")
   `LPCP_ASSERT_SAME(a_args_need_accept, clock, reset,
      rsp_valid && rsp_data.with_arguments, rsp_data.accepted,
      "with_arguments set on a rejected message")
   `LPCP_ASSERT_NEXT(a_stage_holds, clock, reset,
      s1_valid_ff && !room, s1_valid_ff && $stable(s1_item_ff),
      "input register changed while blocked")
   `LPCP_ASSERT_SAME(a_half_on_split, clock, reset,
      half_ff, rsp_valid && head.has_payload && head.has_verdict,
      "split flag set without a payload and verdict entry at the head")

endmodule

`default_nettype wire
